// ===== src/dtrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the disc track range checker.
// Depends on nothing; every other file of the block imports it.
package dtrc_pkg;

	localparam int SEC_W = 32;
	localparam int CNT_W = 8;
	localparam int WALK_W = 9;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_RANGE   = 3'd2,
		ST_GAP     = 3'd3,
		ST_AUDIO   = 3'd4
	} status_t;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_CHECK = 1'b1
	} req_t;

	typedef struct packed {
		logic [SEC_W-1:0] start_sec;
		logic [SEC_W-1:0] end_sec;
		logic             is_data;
	} track_entry_t;

	typedef struct packed {
		logic             walk_phase;
		logic             first;
		logic             last;
		logic             mode1;
		logic [SEC_W-1:0] prev_end;
		logic [SEC_W:0]   cursor;
		logic [SEC_W:0]   range_end;
	} step_ctx_t;

	typedef struct packed {
		logic           stop;
		status_t        code;
		logic [SEC_W:0] cursor_nxt;
	} step_res_t;

endpackage

// ===== src/dtrc_track_mem.sv =====
`timescale 1ns / 1ps
// Track table storage: entry memory with one write and one registered read port,
// plus written marks held in flip-flops that reset clears. Uses dtrc_pkg.
module dtrc_track_mem import dtrc_pkg::*; #(
	parameter int MAX_TRACKS = 128,
	parameter int AW = 7
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [AW-1:0] waddr,
	input  track_entry_t wdata,
	input  logic         rd_en,
	input  logic [AW-1:0] raddr,
	output track_entry_t rdata,
	output logic         rwritten
);

	track_entry_t entry_mem [MAX_TRACKS];
	logic [MAX_TRACKS-1:0] written_q;
	track_entry_t rd_entry_q;
	logic rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_entry_q <= entry_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[waddr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[raddr];
			end
		end
	end

	assign rdata = rd_entry_q;
	assign rwritten = rd_written_q;

endmodule

// ===== src/dtrc_step_unit.sv =====
`timescale 1ns / 1ps
// Shared compare unit: judges one table entry, either for table validation
// or for one step of the range walk. Uses dtrc_pkg.
module dtrc_step_unit import dtrc_pkg::*; #(
	parameter logic [SEC_W-1:0] SECTOR_LIMIT = 32'd1048576
) (
	input  track_entry_t entry,
	input  logic         written,
	input  step_ctx_t    ctx,
	output step_res_t    res
);

	logic [SEC_W:0] start_x;
	logic [SEC_W:0] end_x;
	logic [SEC_W:0] clip;
	logic bad;

	assign start_x = {1'b0, entry.start_sec};
	assign end_x = {1'b0, entry.end_sec};
	assign clip = (end_x < ctx.range_end) ? end_x : ctx.range_end;
	assign bad = !written || (entry.start_sec >= entry.end_sec) ||
		(entry.end_sec > SECTOR_LIMIT) ||
		(!ctx.first && (ctx.prev_end > entry.start_sec));

	always_comb begin
		res.stop = 1'b0;
		res.code = ST_OK;
		res.cursor_nxt = ctx.cursor;
		if (!ctx.walk_phase) begin
			if (bad) begin
				res.stop = 1'b1;
				res.code = ST_INVALID;
			end
		end else if (end_x <= ctx.cursor) begin
			res.stop = ctx.last;
			res.code = ST_RANGE;
		end else if (start_x > ctx.cursor) begin
			res.stop = 1'b1;
			res.code = ST_GAP;
		end else if (ctx.mode1 && !entry.is_data) begin
			res.stop = 1'b1;
			res.code = ST_AUDIO;
		end else begin
			res.cursor_nxt = clip;
			res.stop = (clip == ctx.range_end) || ctx.last;
			res.code = (clip == ctx.range_end) ? ST_OK : ST_RANGE;
		end
	end

endmodule

// ===== src/disc_track_range_checker_unit.sv =====
`timescale 1ns / 1ps
// Top level of the disc track range checker: command port, sequencer and
// configuration register. Uses dtrc_pkg, dtrc_track_mem and dtrc_step_unit.
//
// A write answers on done in the cycle after it is taken, and so does a check
// that is rejected at once (empty or oversized table count, zero sector
// total); busy stays low for these. Any other check holds busy high while it
// runs, and its status beat comes in the same cycle as busy falls. The track
// memory has a single read port, and every entry in use is read once to validate
// the table and once more to walk the range, one entry per cycle, with early
// exit on the first failure.
// The status beat is shown for exactly one cycle with done high, and the
// receiver must take it then; a new command may be started in that cycle.
module disc_track_range_checker_unit import dtrc_pkg::*; #(
	parameter int MAX_TRACKS = 128,
	parameter logic [31:0] SECTOR_LIMIT = 32'd1048576
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        req_type,
	input  logic [6:0]  entry_index,
	input  logic [31:0] entry_start,
	input  logic [31:0] entry_end,
	input  logic        entry_is_data,
	input  logic [31:0] first_sector,
	input  logic [31:0] sector_total,
	input  logic        want_mode1,
	output logic [2:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_VAL,
		S_RNG,
		S_WALK
	} state_t;

	state_t state_q;
	logic busy_q;
	logic done_q;
	status_t status_q;
	logic [CNT_W-1:0] track_count_q;
	logic [WALK_W-1:0] iss_q;
	logic vld_s1;
	logic first_s1;
	logic last_s1;
	logic [SEC_W-1:0] first_q;
	logic [SEC_W:0] range_end_q;
	logic mode1_q;
	logic [SEC_W-1:0] first_start_q;
	logic [SEC_W-1:0] prev_end_q;
	logic [SEC_W:0] cursor_q;

	logic accept;
	logic wr_ok;
	logic wr_en;
	logic issue;
	logic [WALK_W-1:0] cnt_x;
	logic cnt_bad;
	track_entry_t wdata;
	track_entry_t rdata;
	logic rwritten;
	step_ctx_t ctx;
	step_res_t res;

	assign accept = start && !busy_q;
	assign cnt_x = {1'b0, track_count_q};
	assign cnt_bad = (track_count_q == '0) || (cnt_x > WALK_W'(MAX_TRACKS));
	assign wr_ok = {2'b00, entry_index} < WALK_W'(MAX_TRACKS);
	assign wr_en = accept && (req_type == REQ_WRITE) && wr_ok;
	assign issue = ((state_q == S_VAL) || (state_q == S_WALK)) && (iss_q < cnt_x);
	assign wdata = '{start_sec: entry_start, end_sec: entry_end, is_data: entry_is_data};

	dtrc_track_mem #(
		.MAX_TRACKS(MAX_TRACKS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.waddr(AW'(entry_index)),
		.wdata(wdata),
		.rd_en(issue),
		.raddr(iss_q[AW-1:0]),
		.rdata(rdata),
		.rwritten(rwritten)
	);

	assign ctx = '{
		walk_phase: (state_q == S_WALK),
		first: first_s1,
		last: last_s1,
		mode1: mode1_q,
		prev_end: prev_end_q,
		cursor: cursor_q,
		range_end: range_end_q
	};

	dtrc_step_unit #(
		.SECTOR_LIMIT(SECTOR_LIMIT)
	) u_step (
		.entry(rdata),
		.written(rwritten),
		.ctx(ctx),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			status_q <= ST_OK;
			track_count_q <= '0;
			iss_q <= '0;
			vld_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1 <= 1'b0;
			first_q <= '0;
			range_end_q <= '0;
			mode1_q <= 1'b0;
			first_start_q <= '0;
			prev_end_q <= '0;
			cursor_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				track_count_q <= cfg_data;
			end
			vld_s1 <= issue && !(vld_s1 && res.stop);
			if (issue) begin
				iss_q <= iss_q + 1'b1;
				first_s1 <= (iss_q == '0);
				last_s1 <= (iss_q == cnt_x - 1'b1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == REQ_WRITE) begin
							done_q <= 1'b1;
							status_q <= wr_ok ? ST_OK : ST_INVALID;
						end else if (cnt_bad || (sector_total == '0)) begin
							done_q <= 1'b1;
							status_q <= ST_INVALID;
						end else begin
							busy_q <= 1'b1;
							state_q <= S_VAL;
							iss_q <= '0;
							first_q <= first_sector;
							range_end_q <= {1'b0, first_sector} + {1'b0, sector_total};
							mode1_q <= want_mode1;
						end
					end
				end
				S_VAL: begin
					if (vld_s1) begin
						prev_end_q <= rdata.end_sec;
						if (first_s1) begin
							first_start_q <= rdata.start_sec;
						end
						if (res.stop) begin
							done_q <= 1'b1;
							status_q <= res.code;
							busy_q <= 1'b0;
							state_q <= S_IDLE;
						end else if (last_s1) begin
							state_q <= S_RNG;
						end
					end
				end
				S_RNG: begin
					if ((first_q < first_start_q) || (range_end_q > {1'b0, prev_end_q})) begin
						done_q <= 1'b1;
						status_q <= ST_RANGE;
						busy_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WALK;
						iss_q <= '0;
						cursor_q <= {1'b0, first_q};
					end
				end
				S_WALK: begin
					if (vld_s1) begin
						cursor_q <= res.cursor_nxt;
						if (res.stop) begin
							done_q <= 1'b1;
							status_q <= res.code;
							busy_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign status = status_q;
	assign cfg_ready = !busy_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");

	a_write_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == REQ_WRITE)) |=> (done && !busy))
		else $error("write command not answered in the next cycle");

	a_busy_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !done)
		else $error("status beat given as a check starts");

	a_fetch_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ((state_q == S_VAL) || (state_q == S_WALK)))
		else $error("entry read outside a table pass");

	a_idle_iff_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !busy_q)
		else $error("sequencer idle while busy");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for disc_track_range_checker_unit: writes track tables, sets the
// track count and checks sector ranges, comparing each status beat with its own prediction.
// Depends on dtrc_pkg and the RTL of the block only.
module testbench;
	import dtrc_pkg::*;

	localparam int          MAX_TRACKS   = 128;
	localparam logic [31:0] SECTOR_LIMIT = 32'd1048576;
	localparam int          ITEM_TARGET  = 1050;
	localparam int          CYCLE_LIMIT  = 1500000;

	typedef struct {
		req_t        req;
		logic [6:0]  idx;
		logic [31:0] s_start;
		logic [31:0] s_end;
		logic        is_data;
		logic [31:0] first;
		logic [31:0] total;
		logic        mode1;
	} disc_cmd_t;

	class track_scoreboard;
		logic [31:0] starts[MAX_TRACKS];
		logic [31:0] ends[MAX_TRACKS];
		bit          data_flag[MAX_TRACKS];
		bit          written[MAX_TRACKS];
		logic [7:0]  track_count;
		status_t     pending[$];
		int          errors;

		function new();
			for (int i = 0; i < MAX_TRACKS; i++) begin
				starts[i] = '0;
				ends[i] = '0;
			end
			track_count = '0;
			errors = 0;
		endfunction

		function bit table_ok();
			int cnt;
			cnt = int'(track_count);
			if (cnt == 0 || cnt > MAX_TRACKS)
				return 0;
			for (int i = 0; i < cnt; i++) begin
				if (!written[i] || starts[i] >= ends[i] || ends[i] > SECTOR_LIMIT)
					return 0;
				if (i > 0 && ends[i-1] > starts[i])
					return 0;
			end
			return 1;
		endfunction

		function status_t range_status(logic [31:0] first, logic [31:0] total, bit mode1);
			logic [32:0] stop_at;
			logic [32:0] cursor;
			int          cnt;
			cnt = int'(track_count);
			if (!table_ok() || total == 0)
				return ST_INVALID;
			stop_at = {1'b0, first} + {1'b0, total};
			if (first < starts[0] || stop_at > {1'b0, ends[cnt-1]})
				return ST_RANGE;
			cursor = {1'b0, first};
			for (int i = 0; i < cnt && cursor < stop_at; i++) begin
				if ({1'b0, ends[i]} <= cursor)
					continue;
				if ({1'b0, starts[i]} > cursor)
					return ST_GAP;
				if (mode1 && !data_flag[i])
					return ST_AUDIO;
				cursor = ({1'b0, ends[i]} < stop_at) ? {1'b0, ends[i]} : stop_at;
			end
			return (cursor == stop_at) ? ST_OK : ST_RANGE;
		endfunction

		function void note_item(disc_cmd_t c);
			if (c.req == REQ_WRITE) begin
				if (int'(c.idx) < MAX_TRACKS) begin
					starts[c.idx] = c.s_start;
					ends[c.idx] = c.s_end;
					data_flag[c.idx] = c.is_data;
					written[c.idx] = 1'b1;
					pending.push_back(ST_OK);
				end else begin
					pending.push_back(ST_INVALID);
				end
			end else begin
				pending.push_back(range_status(c.first, c.total, c.mode1));
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_status(logic [2:0] got);
			status_t want;
			if (pending.size() == 0) begin
				report($sformatf("status beat %0d with nothing outstanding", got));
				return;
			end
			want = pending.pop_front();
			if (got !== want)
				report($sformatf("status %0d, expected %0d (%s)", got, want, want.name()));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	logic        req_type;
	logic [6:0]  entry_index;
	logic [31:0] entry_start;
	logic [31:0] entry_end;
	logic        entry_is_data;
	logic [31:0] first_sector;
	logic [31:0] sector_total;
	logic        want_mode1;
	logic [2:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	track_scoreboard sb = new();

	logic [31:0] lay_lo[MAX_TRACKS];
	logic [31:0] lay_hi[MAX_TRACKS];
	bit          lay_data[MAX_TRACKS];
	int          lay_n = 0;
	int          items_sent = 0;
	bit          idle_on = 1;
	int          cycles = 0;

	disc_track_range_checker_unit #(
		.MAX_TRACKS(MAX_TRACKS),
		.SECTOR_LIMIT(SECTOR_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.req_type(req_type),
		.entry_index(entry_index),
		.entry_start(entry_start),
		.entry_end(entry_end),
		.entry_is_data(entry_is_data),
		.first_sector(first_sector),
		.sector_total(sector_total),
		.want_mode1(want_mode1),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_status(status);
	end

	function automatic disc_cmd_t mk_write(logic [6:0] idx, logic [31:0] s, logic [31:0] e,
			logic d);
		disc_cmd_t c;
		c.req = REQ_WRITE;
		c.idx = idx;
		c.s_start = s;
		c.s_end = e;
		c.is_data = d;
		c.first = $urandom;
		c.total = $urandom;
		c.mode1 = 1'($urandom_range(0, 1));
		return c;
	endfunction

	function automatic disc_cmd_t mk_check(logic [31:0] f, logic [31:0] t, logic m);
		disc_cmd_t c;
		c.req = REQ_CHECK;
		c.idx = 7'($urandom);
		c.s_start = $urandom;
		c.s_end = $urandom;
		c.is_data = 1'($urandom_range(0, 1));
		c.first = f;
		c.total = t;
		c.mode1 = m;
		return c;
	endfunction

	function automatic int next_gap();
		if (!idle_on || items_sent >= ITEM_TARGET - 120)
			return 0;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(1, 9);
		return 0;
	endfunction

	// Entered and left at a falling edge; start stays high when the next beat follows at once.
	task automatic issue(disc_cmd_t c, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type <= c.req;
		entry_index <= c.idx;
		entry_start <= c.s_start;
		entry_end <= c.s_end;
		entry_is_data <= c.is_data;
		first_sector <= c.first;
		sector_total <= c.total;
		want_mode1 <= c.mode1;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_item(c);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic set_track_count(logic [7:0] value);
		start <= 1'b0;
		while (sb.pending.size() != 0 || busy)
			@(negedge clk);
		repeat (2) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.track_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void make_layout(int n);
		logic [31:0] pos;
		int          max_len;
		max_len = (n <= 8) ? 20000 : 2000;
		pos = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(1, 500));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 2) == 0)
				pos += $urandom_range(1, 300);
			lay_lo[i] = pos;
			pos += $urandom_range(1, max_len);
			lay_hi[i] = pos;
			lay_data[i] = ($urandom_range(0, 4) != 0);
		end
		if ($urandom_range(0, 3) == 0)
			lay_hi[n-1] = SECTOR_LIMIT;
		lay_n = n;
	endfunction

	function automatic disc_cmd_t random_check();
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] f;
		logic [31:0] t;
		int          k;
		int          i;
		k = $urandom_range(0, 11);
		if (lay_n == 0 || k == 0)
			return mk_check($urandom, $urandom, 1'($urandom_range(0, 1)));
		if (k == 1)
			return mk_check(lay_lo[0] + $urandom_range(0, 50), '0, 1'($urandom_range(0, 1)));
		lo = lay_lo[0];
		hi = lay_hi[lay_n-1];
		if (k <= 4) begin
			i = $urandom_range(0, lay_n - 1);
			f = lay_lo[i] + $urandom_range(0, lay_hi[i] - lay_lo[i] - 1);
			t = $urandom_range(1, lay_hi[i] - f);
		end else begin
			f = lo + $urandom_range(0, hi - lo - 1);
			if (k == 5 && lo > 0)
				f = lo - 1;
			t = (k == 6) ? hi - f + $urandom_range(1, 4) : 32'($urandom_range(1, hi - f));
		end
		return mk_check(f, t, 1'($urandom_range(0, 1)));
	endfunction

	initial begin
		int          n;
		int          r;
		int          idx;
		int          big_left;
		logic [31:0] bad_start;
		logic [31:0] bad_end;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_WRITE;
		entry_index = '0;
		entry_start = '0;
		entry_end = '0;
		entry_is_data = 1'b0;
		first_sector = '0;
		sector_total = '0;
		want_mode1 = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table, then a four-track table with an unwritten fifth entry in use.
		set_track_count(8'd0);
		issue(mk_check(32'd20, 32'd5, 1'b0), 0);
		issue(mk_write(7'd0, 32'd10, 32'd100, 1'b1), next_gap());
		issue(mk_write(7'd1, 32'd100, 32'd200, 1'b0), next_gap());
		issue(mk_write(7'd2, 32'd250, 32'd400, 1'b1), next_gap());
		issue(mk_write(7'd3, 32'd400, SECTOR_LIMIT, 1'b1), next_gap());
		set_track_count(8'd5);
		issue(mk_check(32'd20, 32'd5, 1'b0), 0);
		set_track_count(8'd4);
		issue(mk_check(32'd10, 32'd90, 1'b1), 0);
		issue(mk_check(32'd50, 32'd100, 1'b0), next_gap());
		issue(mk_check(32'd50, 32'd100, 1'b1), next_gap());
		issue(mk_check(32'd150, 32'd150, 1'b0), next_gap());
		issue(mk_check(32'd5, 32'd10, 1'b0), next_gap());
		issue(mk_check(SECTOR_LIMIT - 10, 32'd11, 1'b0), next_gap());
		issue(mk_check(SECTOR_LIMIT - 1, 32'd1, 1'b1), next_gap());
		issue(mk_check(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), next_gap());
		issue(mk_check(32'd20, 32'd0, 1'b0), next_gap());
		issue(mk_check(32'hFFFF_FFFF, 32'd1, 1'b0), next_gap());
		set_track_count(8'd129);
		issue(mk_check(32'd20, 32'd5, 1'b0), 0);
		set_track_count(8'd255);
		issue(mk_check(32'd20, 32'd5, 1'b0), 0);
		set_track_count(8'd4);
		issue(mk_write(7'd2, 32'd150, 32'd400, 1'b1), 0);
		issue(mk_check(32'd20, 32'd5, 1'b0), next_gap());
		issue(mk_write(7'd2, 32'd400, 32'd400, 1'b1), next_gap());
		issue(mk_check(32'd20, 32'd5, 1'b0), next_gap());
		issue(mk_write(7'd2, 32'd250, 32'd400, 1'b1), next_gap());
		issue(mk_write(7'd3, 32'd400, SECTOR_LIMIT + 1, 1'b1), next_gap());
		issue(mk_check(32'd20, 32'd5, 1'b0), next_gap());

		big_left = 2;
		n = MAX_TRACKS;
		while (items_sent < ITEM_TARGET) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if (n > 0) begin
				make_layout(n);
				for (int i = 0; i < n; i++)
					issue(mk_write(7'(i), lay_lo[i], lay_hi[i], lay_data[i]), next_gap());
				if (n < MAX_TRACKS) begin
					repeat ($urandom_range(0, 2))
						issue(mk_write(7'($urandom_range(n, MAX_TRACKS - 1)), $urandom,
							$urandom, 1'($urandom_range(0, 1))), next_gap());
				end
				// A broken entry now and then: empty, inverted, past the limit or overlapping.
				if ($urandom_range(0, 99) < 15) begin
					idx = $urandom_range(0, n - 1);
					bad_start = lay_lo[idx];
					bad_end = lay_hi[idx];
					case ($urandom_range(0, 3))
						0: bad_end = lay_lo[idx];
						1: begin
							bad_start = lay_hi[idx];
							bad_end = lay_lo[idx];
						end
						2: bad_end = $urandom_range(0, 1) ? SECTOR_LIMIT + $urandom_range(1, 4096)
							: ($urandom | 32'h8000_0000);
						default: begin
							if (idx > 0)
								bad_start = lay_hi[idx-1] - 1;
							else
								bad_end = lay_lo[idx];
						end
					endcase
					issue(mk_write(7'(idx), bad_start, bad_end, lay_data[idx]), next_gap());
				end
				set_track_count(8'(n));
			end else begin
				set_track_count($urandom_range(0, 1) ? 8'd0
					: 8'($urandom_range(MAX_TRACKS + 1, 255)));
			end
			repeat ($urandom_range(8, 24))
				issue(random_check(), next_gap());
			r = $urandom_range(0, 99);
			if (r < 3 && big_left > 0) begin
				n = MAX_TRACKS;
				big_left--;
			end else if (r < 8) begin
				n = 0;
			end else if (r < 20) begin
				n = $urandom_range(9, 40);
			end else begin
				n = $urandom_range(1, 8);
			end
		end

		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== disc_track_range_checker_unit.f =====
src/dtrc_pkg.sv
src/dtrc_track_mem.sv
src/dtrc_step_unit.sv
src/disc_track_range_checker_unit.sv
test/testbench.sv
